### rtl/core/rsf_pkg.sv
// ----------------------------------------------------------------------------
// rsf_pkg: shared types and constants of the RTP stream source filter
// Table depths, index widths, register indexes, the structs passed between
// the scan unit, the tables and the sequencer, and free-slot search helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package rsf_pkg;

  localparam int BOUND_DEPTH  = 8;
  localparam int REMOTE_DEPTH = 16;

  localparam int BIDX_W = (BOUND_DEPTH > 1) ? $clog2(BOUND_DEPTH) : 1;
  localparam int RIDX_W = (REMOTE_DEPTH > 1) ? $clog2(REMOTE_DEPTH) : 1;
  localparam int SCAN_W = (BIDX_W > RIDX_W) ? BIDX_W : RIDX_W;

  localparam int SRC_W = 32;
  localparam int TAG_W = 64;
  localparam int PT_W  = 7;
  localparam int CFG_W = 64;
  localparam int CIDX_W = 2;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_STREAM_TAG   = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_TAG_VALID    = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_UNIQUE_LOW   = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_UNIQUE_HIGH  = 2'd3;

  // Read request from the scan unit into the tables.
  typedef struct packed {
    logic              remote;
    logic [SCAN_W-1:0] idx;
  } rd_req_t;

  // Entry presented by the tables for the current read request.
  typedef struct packed {
    logic             valid;
    logic [SRC_W-1:0] entry;
  } rd_rsp_t;

  // Outcome of one table scan, held until the next scan starts.
  typedef struct packed {
    logic              done;
    logic              hit;
    logic [SCAN_W-1:0] hit_idx;
  } scan_res_t;

  // Table update request from the sequencer.
  typedef struct packed {
    logic              clr_bind;
    logic              b_clr;
    logic [BIDX_W-1:0] b_clr_idx;
    logic              b_set;
    logic [BIDX_W-1:0] b_set_idx;
    logic              r_set;
    logic [RIDX_W-1:0] r_set_idx;
    logic [SRC_W-1:0]  data;
  } tbl_wr_t;

  typedef struct packed {
    logic              found;
    logic [BIDX_W-1:0] idx;
  } bfree_t;

  typedef struct packed {
    logic              found;
    logic [RIDX_W-1:0] idx;
  } rfree_t;

  // Lowest free slot of the bound table.
  function automatic bfree_t bound_free(input logic [BOUND_DEPTH-1:0] valid);
    bfree_t res;
    res = '0;
    for (int i = BOUND_DEPTH - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        res.found = 1'b1;
        res.idx   = BIDX_W'(i);
      end
    end
    return res;
  endfunction

  // Lowest free slot of the remote table.
  function automatic rfree_t remote_free(input logic [REMOTE_DEPTH-1:0] valid);
    rfree_t res;
    res = '0;
    for (int i = REMOTE_DEPTH - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        res.found = 1'b1;
        res.idx   = RIDX_W'(i);
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/core/rsf_tables.sv
// ----------------------------------------------------------------------------
// rsf_tables: bound and remote source id tables
// Holds the entries and their valid bits, presents one entry per cycle to
// the scan unit and applies set, clear and clear-all updates.
// ----------------------------------------------------------------------------
`default_nettype none

module rsf_tables import rsf_pkg::*; (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  rd_req_t                 rd_req_i,
  output rd_rsp_t                 rd_rsp_o,
  input  tbl_wr_t                 wr_i,
  output logic [BOUND_DEPTH-1:0]  bound_valid_o,
  output logic [REMOTE_DEPTH-1:0] remote_valid_o
);

  logic [SRC_W-1:0]        bound_q  [BOUND_DEPTH];
  logic [SRC_W-1:0]        remote_q [REMOTE_DEPTH];
  logic [BOUND_DEPTH-1:0]  bvalid_q, bvalid_d;
  logic [REMOTE_DEPTH-1:0] rvalid_q, rvalid_d;
  logic [BIDX_W-1:0]       b_rd_idx;
  logic [RIDX_W-1:0]       r_rd_idx;

  assign b_rd_idx = rd_req_i.idx[BIDX_W-1:0];
  assign r_rd_idx = rd_req_i.idx[RIDX_W-1:0];

  always_comb begin
    if (rd_req_i.remote) begin
      rd_rsp_o.valid = rvalid_q[r_rd_idx];
      rd_rsp_o.entry = remote_q[r_rd_idx];
    end else begin
      rd_rsp_o.valid = bvalid_q[b_rd_idx];
      rd_rsp_o.entry = bound_q[b_rd_idx];
    end
  end

  always_comb begin
    bvalid_d = bvalid_q;
    if (wr_i.b_clr) begin
      bvalid_d[wr_i.b_clr_idx] = 1'b0;
    end
    if (wr_i.b_set) begin
      bvalid_d[wr_i.b_set_idx] = 1'b1;
    end
    if (wr_i.clr_bind) begin
      bvalid_d = '0;
    end
    rvalid_d = rvalid_q;
    if (wr_i.r_set) begin
      rvalid_d[wr_i.r_set_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bvalid_q <= '0;
      rvalid_q <= '0;
    end else begin
      bvalid_q <= bvalid_d;
      rvalid_q <= rvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.b_set) begin
      bound_q[wr_i.b_set_idx] <= wr_i.data;
    end
    if (wr_i.r_set) begin
      remote_q[wr_i.r_set_idx] <= wr_i.data;
    end
  end

  assign bound_valid_o  = bvalid_q;
  assign remote_valid_o = rvalid_q;

endmodule

`default_nettype wire

### rtl/core/rsf_scan.sv
// ----------------------------------------------------------------------------
// rsf_scan: shared source id compare unit
// Walks one table an entry per cycle through a single 32-bit comparator and
// stops at the first valid entry equal to the key or after the last entry.
// ----------------------------------------------------------------------------
`default_nettype none

module rsf_scan import rsf_pkg::*; (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              start_i,
  input  wire              remote_i,
  input  wire  [SRC_W-1:0] key_i,
  output rd_req_t          rd_req_o,
  input  rd_rsp_t          rd_rsp_i,
  output scan_res_t        res_o
);

  logic              active_q, active_d;
  logic              remote_q, remote_d;
  logic [SCAN_W-1:0] idx_q, idx_d;
  logic [SRC_W-1:0]  key_q, key_d;
  logic              hit_q, hit_d;
  logic [SCAN_W-1:0] hit_idx_q, hit_idx_d;
  logic              done_q, done_d;
  logic              match;
  logic              last;

  assign match = rd_rsp_i.valid && (rd_rsp_i.entry == key_q);
  assign last  = remote_q ? (idx_q == SCAN_W'(REMOTE_DEPTH - 1))
                          : (idx_q == SCAN_W'(BOUND_DEPTH - 1));

  always_comb begin
    active_d  = active_q;
    remote_d  = remote_q;
    idx_d     = idx_q;
    key_d     = key_q;
    hit_d     = hit_q;
    hit_idx_d = hit_idx_q;
    done_d    = 1'b0;
    if (start_i) begin
      active_d = 1'b1;
      remote_d = remote_i;
      idx_d    = '0;
      key_d    = key_i;
      hit_d    = 1'b0;
    end else if (active_q) begin
      if (match) begin
        hit_d     = 1'b1;
        hit_idx_d = idx_q;
        active_d  = 1'b0;
        done_d    = 1'b1;
      end else if (last) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end else begin
        idx_d = idx_q + SCAN_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      hit_q    <= 1'b0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      hit_q    <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    remote_q  <= remote_d;
    idx_q     <= idx_d;
    key_q     <= key_d;
    hit_idx_q <= hit_idx_d;
  end

  assign rd_req_o.remote = remote_q;
  assign rd_req_o.idx    = idx_q;
  assign res_o.done      = done_q;
  assign res_o.hit       = hit_q;
  assign res_o.hit_idx   = hit_idx_q;

endmodule

`default_nettype wire

### rtl/core/rtp_stream_ssrc_filter_core.sv
// ----------------------------------------------------------------------------
// rtp_stream_ssrc_filter_core: RTP stream source filter
// Decides per received RTP header whether the packet belongs to the stream,
// tracks source ids bound to the stream tag and learns remote source ids.
// ----------------------------------------------------------------------------
// Usage:
// An item is taken at a rising clock edge with start_i high and busy_o low.
// The item either filters a packet header (command_i low) or adds source_id_i
// to the remote set (command_i high). Exactly one result follows per item:
// done_o is high for one cycle with accept_o, learned_o and table_full_o
// valid, and the receiver has no way to hold it off.
// Timing: a header first walks the bound table, one entry per cycle through
// the shared comparator, stopping early on a hit. When no binding remains it
// walks the remote table the same way; an add command walks only the remote
// table. busy_o drops in the cycle done_o is shown, so the next item can be
// taken right then. The walk length through the comparator sets the rate.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i while
// the block is idle; a write to the stream tag or its valid flag clears all
// bindings. Reset empties both tables and zeroes the config registers.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_stream_ssrc_filter_core import rsf_pkg::*; (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              cfg_we_i,
  input  wire [CIDX_W-1:0] cfg_idx_i,
  input  wire [CFG_W-1:0]  cfg_data_i,
  input  wire              start_i,
  output logic             busy_o,
  input  wire              command_i,
  input  wire [SRC_W-1:0]  source_id_i,
  input  wire              tag_present_i,
  input  wire [TAG_W-1:0]  packet_tag_i,
  input  wire [PT_W-1:0]   payload_kind_i,
  output logic             done_o,
  output logic             accept_o,
  output logic             learned_o,
  output logic             table_full_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_BSCAN = 3'b010,
    ST_RSCAN = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [TAG_W-1:0] stream_tag_q;
  logic             tag_valid_q;
  logic [63:0]      uniq_low_q;
  logic [63:0]      uniq_high_q;

  // Item held for the length of its walk.
  logic             command_q;
  logic [SRC_W-1:0] source_q;
  logic             tagged_q;
  logic             matches_q;
  logic [PT_W-1:0]  pt_q;

  // Result registers.
  logic done_q, done_d;
  logic accept_q, accept_d;
  logic learned_q, learned_d;
  logic full_q, full_d;

  logic      take;
  logic      scan_start;
  logic      scan_remote;
  logic [SRC_W-1:0] scan_key;
  rd_req_t   rd_req;
  rd_rsp_t   rd_rsp;
  scan_res_t scan_res;
  tbl_wr_t   wr;
  logic [BOUND_DEPTH-1:0]  bvalid;
  logic [REMOTE_DEPTH-1:0] rvalid;

  bfree_t bfree;
  rfree_t rfree;
  logic [BIDX_W-1:0]      slot;
  logic                   unbind;
  logic                   b_ins;
  logic [BOUND_DEPTH-1:0] clr_vec;
  logic [BOUND_DEPTH-1:0] set_vec;
  logic [BOUND_DEPTH-1:0] new_bvalid;
  logic                   any_bound;
  logic                   unique_pt;
  logic                   r_ins;

  assign busy_o = (state_q != ST_IDLE);
  assign take   = start_i && !busy_o;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_tag_q <= '0;
      tag_valid_q  <= 1'b0;
      uniq_low_q   <= '0;
      uniq_high_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STREAM_TAG:  stream_tag_q <= cfg_data_i;
        CFG_TAG_VALID:   tag_valid_q  <= cfg_data_i[0];
        CFG_UNIQUE_LOW:  uniq_low_q   <= cfg_data_i;
        CFG_UNIQUE_HIGH: uniq_high_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The tag compare is done once, as the item is taken.
  always_ff @(posedge clk_i) begin
    if (take) begin
      command_q <= command_i;
      source_q  <= source_id_i;
      tagged_q  <= tag_present_i;
      matches_q <= tag_present_i && tag_valid_q && (packet_tag_i == stream_tag_q);
      pt_q      <= payload_kind_i;
    end
  end

  // Bound table decision, evaluated when the bound walk finishes.
  assign bfree      = bound_free(bvalid);
  assign slot       = scan_res.hit_idx[BIDX_W-1:0];
  assign unbind     = scan_res.hit && tagged_q && !matches_q;
  assign b_ins      = matches_q && !scan_res.hit;
  assign clr_vec    = unbind ? (BOUND_DEPTH'(1) << slot) : '0;
  assign set_vec    = (b_ins && bfree.found) ? (BOUND_DEPTH'(1) << bfree.idx) : '0;
  assign new_bvalid = (bvalid & ~clr_vec) | set_vec;
  assign any_bound  = |new_bvalid;

  // Remote table decision, evaluated when the remote walk finishes.
  assign rfree     = remote_free(rvalid);
  assign unique_pt = pt_q[PT_W-1] ? uniq_high_q[pt_q[PT_W-2:0]] : uniq_low_q[pt_q[PT_W-2:0]];
  assign r_ins     = !scan_res.hit && (command_q || unique_pt);

  always_comb begin
    state_d     = state_q;
    scan_start  = 1'b0;
    scan_remote = 1'b0;
    scan_key    = source_q;
    done_d      = 1'b0;
    accept_d    = accept_q;
    learned_d   = learned_q;
    full_d      = full_q;
    wr          = '0;
    wr.data     = source_q;
    wr.clr_bind = cfg_we_i && ((cfg_idx_i == CFG_STREAM_TAG) || (cfg_idx_i == CFG_TAG_VALID));
    wr.b_clr_idx = slot;
    wr.b_set_idx = bfree.idx;
    wr.r_set_idx = rfree.idx;

    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          scan_start  = 1'b1;
          scan_remote = command_i;
          scan_key    = source_id_i;
          state_d     = command_i ? ST_RSCAN : ST_BSCAN;
        end
      end
      ST_BSCAN: begin
        if (scan_res.done) begin
          wr.b_clr = unbind;
          wr.b_set = b_ins && bfree.found;
          if (any_bound) begin
            // Only bound ids pass while a binding exists.
            done_d    = 1'b1;
            accept_d  = (scan_res.hit && !unbind) || (b_ins && bfree.found);
            learned_d = 1'b0;
            full_d    = b_ins && !bfree.found;
            state_d   = ST_IDLE;
          end else begin
            scan_start  = 1'b1;
            scan_remote = 1'b1;
            state_d     = ST_RSCAN;
          end
        end
      end
      ST_RSCAN: begin
        if (scan_res.done) begin
          wr.r_set  = r_ins && rfree.found;
          done_d    = 1'b1;
          accept_d  = !command_q && (scan_res.hit || unique_pt);
          learned_d = r_ins && rfree.found;
          full_d    = r_ins && !rfree.found;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    accept_q  <= accept_d;
    learned_q <= learned_d;
    full_q    <= full_d;
  end

  rsf_scan u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (scan_start),
    .remote_i (scan_remote),
    .key_i    (scan_key),
    .rd_req_o (rd_req),
    .rd_rsp_i (rd_rsp),
    .res_o    (scan_res)
  );

  rsf_tables u_tables (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rd_req_i       (rd_req),
    .rd_rsp_o       (rd_rsp),
    .wr_i           (wr),
    .bound_valid_o  (bvalid),
    .remote_valid_o (rvalid)
  );

  assign done_o       = done_q;
  assign accept_o     = accept_q;
  assign learned_o    = learned_q;
  assign table_full_o = full_q;

  // The sequencer returns to idle in the same edge that shows a result.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while still busy");

  // An insert either succeeds or is dropped, never both.
  a_learn_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(learned_o && table_full_o))
    else $error("learned and table_full both set");

  // A taken item keeps the block busy in the following cycle.
  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o))
    else $error("item taken but block not busy");

  // No scan reports back while the sequencer is idle.
  a_scan_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !scan_res.done)
    else $error("scan finished while sequencer idle");

endmodule

`default_nettype wire

### test/rtp_stream_ssrc_filter_core_test.sv
// ----------------------------------------------------------------------------
// rtp_stream_ssrc_filter_core_test: self-checking bench of the source filter
// Drives packet headers and remote-add commands into the filter core. A
// behavioral model of the bound and remote tables predicts the verdict of
// each accepted item, and every done_o strobe is checked against it. Short
// directed tests come first, then long randomized phases under changing
// configurations with bursty traffic.
// ----------------------------------------------------------------------------

module rtp_stream_ssrc_filter_core_test;
  import rsf_pkg::*;

  // The limit lies far above a correct run and only catches a hung block.
  localparam int CYCLE_LIMIT = 500000;
  localparam int POOL_SIZE   = 24;

  // One result of the filter, in port order.
  typedef struct packed {
    logic accept;
    logic learned;
    logic full;
  } verdict_t;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              cfg_we_i       = 1'b0;
  logic [CIDX_W-1:0] cfg_idx_i      = '0;
  logic [CFG_W-1:0]  cfg_data_i     = '0;
  logic              start_i        = 1'b0;
  logic              busy_o;
  logic              command_i      = 1'b0;
  logic [SRC_W-1:0]  source_id_i    = '0;
  logic              tag_present_i  = 1'b0;
  logic [TAG_W-1:0]  packet_tag_i   = '0;
  logic [PT_W-1:0]   payload_kind_i = '0;
  logic              done_o;
  logic              accept_o;
  logic              learned_o;
  logic              table_full_o;

  rtp_stream_ssrc_filter_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .command_i     (command_i),
    .source_id_i   (source_id_i),
    .tag_present_i (tag_present_i),
    .packet_tag_i  (packet_tag_i),
    .payload_kind_i(payload_kind_i),
    .done_o        (done_o),
    .accept_o      (accept_o),
    .learned_o     (learned_o),
    .table_full_o  (table_full_o)
  );

  always #6 clk_i = ~clk_i;

  // Model copy of the configuration registers.
  logic [TAG_W-1:0] cur_tag   = '0;
  logic             tag_valid = 1'b0;
  logic [CFG_W-1:0] mask_low  = '0;
  logic [CFG_W-1:0] mask_high = '0;

  // Model copy of both tables. An entry is only looked at while its valid
  // flag is set, so the id arrays need no reset value.
  logic [SRC_W-1:0] bound_id  [BOUND_DEPTH];
  bit               bound_ok  [BOUND_DEPTH];
  logic [SRC_W-1:0] remote_id [REMOTE_DEPTH];
  bit               remote_ok [REMOTE_DEPTH];

  verdict_t expected_verdicts[$];
  int       error_count = 0;
  int       cycle_count = 0;

  initial begin
    foreach (bound_ok[i]) bound_ok[i] = 1'b0;
    foreach (remote_ok[i]) remote_ok[i] = 1'b0;
  end

  // Slot of a bound source id, or -1 when it is not bound.
  function automatic int bound_slot(input logic [SRC_W-1:0] sid);
    for (int i = 0; i < BOUND_DEPTH; i++)
      if (bound_ok[i] && bound_id[i] == sid) return i;
    return -1;
  endfunction

  // Puts a source id into the lowest free remote slot. Returns 1 when it was
  // added, 0 when it was already there and -1 when the table is full.
  function automatic int remote_insert(input logic [SRC_W-1:0] sid);
    for (int i = 0; i < REMOTE_DEPTH; i++)
      if (remote_ok[i] && remote_id[i] == sid) return 0;
    for (int i = 0; i < REMOTE_DEPTH; i++) begin
      if (!remote_ok[i]) begin
        remote_id[i] = sid;
        remote_ok[i] = 1'b1;
        return 1;
      end
    end
    return -1;
  endfunction

  // Updates the model tables for one accepted item and returns its verdict.
  function automatic verdict_t filter_verdict(input logic cmd, input logic [SRC_W-1:0] sid,
                                              input logic has_tag, input logic [TAG_W-1:0] tag,
                                              input logic [PT_W-1:0] pt);
    verdict_t         v;
    logic             tag_hit;
    logic             any_bound;
    logic             in_remote;
    logic [CFG_W-1:0] mask;
    int               slot;
    int               r;
    v = '0;
    if (cmd) begin
      r = remote_insert(sid);
      v.learned = (r > 0);
      v.full    = (r < 0);
    end else begin
      tag_hit = has_tag && tag_valid && (tag == cur_tag);
      slot = bound_slot(sid);
      // A tagged packet with the wrong tag releases its source id.
      if (slot >= 0 && has_tag && !tag_hit) bound_ok[slot] = 1'b0;
      if (tag_hit && slot < 0) begin
        slot = -1;
        for (int i = BOUND_DEPTH - 1; i >= 0; i--)
          if (!bound_ok[i]) slot = i;
        if (slot < 0) begin
          v.full = 1'b1;
        end else begin
          bound_id[slot] = sid;
          bound_ok[slot] = 1'b1;
        end
      end
      any_bound = 1'b0;
      foreach (bound_ok[i]) any_bound |= bound_ok[i];
      in_remote = 1'b0;
      foreach (remote_ok[i]) in_remote |= remote_ok[i] && (remote_id[i] == sid);
      if (any_bound) begin
        v.accept = (bound_slot(sid) >= 0);
      end else if (in_remote) begin
        v.accept = 1'b1;
      end else begin
        mask = pt[6] ? mask_high : mask_low;
        if (mask[pt[5:0]]) begin
          // A unique payload type passes even when learning is dropped.
          v.accept = 1'b1;
          r = remote_insert(sid);
          v.learned = (r > 0);
          v.full    = v.full | (r < 0);
        end
      end
    end
    return v;
  endfunction

  // Offers one item and holds it until the block takes it. start_i is left
  // high on return, so a following call keeps the burst going without a gap.
  task automatic send_item(input logic cmd, input logic [SRC_W-1:0] sid, input logic has_tag,
                           input logic [TAG_W-1:0] tag, input logic [PT_W-1:0] pt);
    start_i        <= 1'b1;
    command_i      <= cmd;
    source_id_i    <= sid;
    tag_present_i  <= has_tag;
    packet_tag_i   <= tag;
    payload_kind_i <= pt;
    do @(posedge clk_i); while (busy_o);
    expected_verdicts.push_back(filter_verdict(cmd, sid, has_tag, tag, pt));
  endtask

  task automatic idle_cycles(input int n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Stops offering items until every verdict is in and the block is idle.
  task automatic wait_all_results();
    start_i <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes one configuration register; the model follows at the same edge.
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      CFG_STREAM_TAG: begin
        cur_tag = value;
        foreach (bound_ok[i]) bound_ok[i] = 1'b0;
      end
      CFG_TAG_VALID: begin
        tag_valid = value[0];
        foreach (bound_ok[i]) bound_ok[i] = 1'b0;
      end
      CFG_UNIQUE_LOW:  mask_low = value;
      CFG_UNIQUE_HIGH: mask_high = value;
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Every done_o strobe is checked against the oldest outstanding verdict.
  // Outputs are read right at the edge, before the block updates them.
  always @(posedge clk_i) begin : result_check
    verdict_t want;
    if (rst_ni && done_o) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: result with no item outstanding: accept %b learned %b full %b",
                 $time, accept_o, learned_o, table_full_o);
        error_count++;
      end else begin
        want = expected_verdicts.pop_front();
        if (accept_o !== want.accept) begin
          $display("%0t: accept expected %b, got %b", $time, want.accept, accept_o);
          error_count++;
        end
        if (learned_o !== want.learned) begin
          $display("%0t: learned expected %b, got %b", $time, want.learned, learned_o);
          error_count++;
        end
        if (table_full_o !== want.full) begin
          $display("%0t: table_full expected %b, got %b", $time, want.full, table_full_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog: a block that stops answering ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Out of reset nothing is unique and no stream id is set, so every packet
  // is dropped. A tagged packet cannot match while the tag is not valid,
  // even when its tag equals the reset value of the register.
  task automatic test_reset_state();
    send_item(1'b0, 32'h0000_0000, 1'b0, '0, 7'd0);
    send_item(1'b0, 32'hFFFF_FFFF, 1'b1, '0, 7'd127);
    send_item(1'b0, 32'h8000_0001, 1'b1, '1, 7'd64);
    wait_all_results();
  endtask

  // The add command learns a new id once, ignores a duplicate, and ignores
  // the packet fields. A packet from an added id then passes.
  task automatic test_remote_add();
    send_item(1'b1, 32'h1234_5678, 1'b0, '0, 7'd0);
    send_item(1'b1, 32'h1234_5678, 1'b1, '1, 7'd127);
    send_item(1'b1, 32'hFFFF_FFFF, 1'b1, '0, 7'd63);
    send_item(1'b0, 32'h1234_5678, 1'b0, '1, 7'd5);
    wait_all_results();
  endtask

  // Only the lowest and the highest payload types are unique here. A new id
  // on either one passes and is learned; the next packet passes by the set.
  task automatic test_unique_types();
    write_reg(CFG_UNIQUE_LOW, 64'h0000_0000_0000_0001);
    write_reg(CFG_UNIQUE_HIGH, 64'h8000_0000_0000_0000);
    send_item(1'b0, 32'h0BAD_F00D, 1'b0, '0, 7'd0);
    send_item(1'b0, 32'h0BAD_F00D, 1'b0, '0, 7'd0);
    send_item(1'b0, 32'h7FFF_FFFF, 1'b1, '1, 7'd127);
    send_item(1'b0, 32'h5555_AAAA, 1'b0, '0, 7'd1);
    send_item(1'b0, 32'h5555_AAAA, 1'b0, '0, 7'd64);
    wait_all_results();
  endtask

  // Binding, release on a wrong tag, tag-absent packets that leave the
  // binding alone, and the clearing effect of both tag registers.
  task automatic test_stream_binding();
    logic [TAG_W-1:0] tag;
    tag = {$urandom, $urandom};
    write_reg(CFG_STREAM_TAG, tag);
    write_reg(CFG_TAG_VALID, 64'd1);
    send_item(1'b0, 32'hCAFE_0001, 1'b1, tag, 7'd3);
    send_item(1'b0, 32'h1234_5678, 1'b0, '0, 7'd3);
    send_item(1'b0, 32'hCAFE_0001, 1'b0, '0, 7'd3);
    send_item(1'b0, 32'hCAFE_0001, 1'b1, tag, 7'd3);
    send_item(1'b0, 32'hCAFE_0001, 1'b1, tag ^ 64'd1, 7'd3);
    send_item(1'b0, 32'h1234_5678, 1'b0, '0, 7'd3);
    send_item(1'b0, 32'hCAFE_0002, 1'b1, tag, 7'd3);
    wait_all_results();
    // Dropping the valid flag releases the binding; a matching tag now has
    // no effect and the unique type decides instead.
    write_reg(CFG_TAG_VALID, 64'd0);
    send_item(1'b0, 32'hCAFE_0003, 1'b1, tag, 7'd0);
    wait_all_results();
    write_reg(CFG_TAG_VALID, 64'd1);
    send_item(1'b0, 32'hCAFE_0002, 1'b1, tag, 7'd3);
    wait_all_results();
    // Rewriting the same tag still releases everything.
    write_reg(CFG_STREAM_TAG, tag);
    send_item(1'b0, 32'h1234_5678, 1'b0, '0, 7'd3);
    wait_all_results();
  endtask

  // Random phases. Source ids come mostly from a small pool so that ids are
  // seen again, bound, released and learned, and both tables run full. Tags
  // are often the configured one or one bit away from it. Each phase starts
  // from idle with a fresh mix of register settings.
  task automatic test_random_traffic(input int n_items);
    logic [SRC_W-1:0] id_pool [POOL_SIZE];
    logic [SRC_W-1:0] sid;
    logic [TAG_W-1:0] tag;
    logic [CFG_W-1:0] value;
    logic [PT_W-1:0]  pt;
    logic             cmd;
    logic             has_tag;
    int               per_phase;
    int               burst_left;
    bit               gaps;
    id_pool[0] = 32'h0000_0000;
    id_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = $urandom;
    per_phase = n_items / 12;
    for (int phase = 0; phase < 12; phase++) begin
      wait_all_results();
      for (int m = 0; m < 2; m++) begin
        case ($urandom_range(0, 3))
          0:       value = '0;
          1:       value = '1;
          2:       value = {$urandom, $urandom};
          default: value = {$urandom, $urandom} & {$urandom, $urandom};
        endcase
        if (phase == 0) value = '1;
        if (phase == 1) value = '0;
        write_reg(m == 0 ? CFG_UNIQUE_LOW : CFG_UNIQUE_HIGH, value);
      end
      if (phase < 3 || phase == 5 || $urandom_range(0, 2) != 0) begin
        value = {$urandom, $urandom};
        if (phase == 2) value = '0;
        if (phase == 5) value = '1;
        write_reg(CFG_STREAM_TAG, value);
      end
      if (phase < 3 || $urandom_range(0, 1) != 0) begin
        // Upper bits are noise; only bit 0 counts.
        value = {$urandom, $urandom};
        value[0] = (phase != 1) && ($urandom_range(0, 3) != 0);
        write_reg(CFG_TAG_VALID, value);
      end
      gaps = (phase % 4 != 3);
      burst_left = $urandom_range(1, 12);
      for (int k = 0; k < per_phase; k++) begin
        cmd = ($urandom_range(0, 9) == 0);
        sid = ($urandom_range(0, 6) == 0) ? $urandom : id_pool[$urandom_range(0, POOL_SIZE - 1)];
        has_tag = ($urandom_range(0, 9) < 7);
        case ($urandom_range(0, 3))
          0, 1:    tag = cur_tag;
          2:       tag = cur_tag ^ (64'd1 << $urandom_range(0, 63));
          default: tag = {$urandom, $urandom};
        endcase
        pt = PT_W'($urandom_range(0, 127));
        send_item(cmd, sid, has_tag, tag, pt);
        burst_left--;
        if (burst_left == 0) begin
          if (gaps) idle_cycles($urandom_range(1, 15));
          burst_left = $urandom_range(1, 12);
        end
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_remote_add();
    test_unique_types();
    test_stream_binding();
    test_random_traffic(900);
    wait_all_results();
    repeat (30) @(posedge clk_i);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
